>>> hdl/recursive_mutex_lock_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Recursive mutex lock table: assertion macros
// Concurrent assertion wrappers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_MUTEX_LOCK_TABLE_UNIT_MACROS_SVH
`define RECURSIVE_MUTEX_LOCK_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every rising edge outside reset.
`define RMLT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true at a rising edge outside reset.
`define RMLT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RMLT_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define RMLT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> hdl/rmlt_pkg.sv
// ----------------------------------------------------------------------------
// Recursive mutex lock table: package
// Request and response beats, mutex word layout and the codes used by the table.
// ----------------------------------------------------------------------------
`default_nettype none

package rmlt_pkg;

    localparam int MUTEX_COUNT_DEF = 64;
    localparam int INDEX_W         = 6;
    localparam int TID_W           = 16;
    localparam int CNT_W           = 11;
    localparam int WORD_W          = 32;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_LOCK    = 2'd1,
        MODE_TRYLOCK = 2'd2,
        MODE_UNLOCK  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_MUST_WAIT = 3'd1,
        STATUS_BUSY      = 3'd2,
        STATUS_DEADLOCK  = 3'd3,
        STATUS_COUNT_FULL = 3'd4,
        STATUS_NOT_OWNER = 3'd5,
        STATUS_INVALID   = 3'd6
    } t_status;

    // Mutex kinds, as requested by init and as stored in a word.
    localparam logic [1:0] KIND_NORMAL    = 2'd0;
    localparam logic [1:0] KIND_RECURSIVE = 2'd1;
    localparam logic [1:0] KIND_ERRCHECK  = 2'd2;
    localparam logic [1:0] KIND_REJECTED  = 2'd3;

    // Lock state field of a word.
    localparam logic [1:0] LK_UNLOCKED = 2'd0;
    localparam logic [1:0] LK_LOCKED   = 2'd1;
    localparam logic [1:0] LK_WAITERS  = 2'd2;

    typedef struct packed {
        logic [TID_W-1:0] owner;
        logic [1:0]       kind;
        logic             shared;
        logic [CNT_W-1:0] count;
        logic [1:0]       lock_st;
    } t_mutex_word;

    typedef struct packed {
        t_mode              mode;
        logic [INDEX_W-1:0] mutex_index;
        logic [TID_W-1:0]   thread_id;
        logic [1:0]         mutex_kind;
        logic               retry;
    } t_lock_req;

    typedef struct packed {
        t_status status;
        logic    wake_one;
    } t_lock_rsp;

endpackage

`default_nettype wire

>>> hdl/rmlt_ram.sv
// ----------------------------------------------------------------------------
// Recursive mutex lock table: generic RAM
// One write port, one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module rmlt_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/recursive_mutex_lock_table_unit.sv
// ----------------------------------------------------------------------------
// Recursive mutex lock table unit
// Table of mutex words with init, lock, trylock and unlock requests, each one
// read-modify-write of one word, answered by a status and a wake-one flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Beat
//  request   in         i_req_valid / o_req_ready    t_lock_req (mode, index, tid,
//                                                    kind, retry)
//  response  out        o_rsp_valid / i_rsp_ready    t_lock_rsp (status, wake_one)
//
// A request beat is taken into the update stage while its word is read out of
// the table RAM, whose read port is registered; the update stage then loads the
// response register. A new request can be taken in every cycle while responses
// are taken. After reset a clearing pass writes zero to every word, one word a
// cycle; no request is taken during that pass.
// A response that is not taken holds the word update stage, which in turn
// holds the request side.
`default_nettype none
`include "recursive_mutex_lock_table_unit_macros.svh"

module recursive_mutex_lock_table_unit
    import rmlt_pkg::*;
#(
    parameter int MUTEX_COUNT = MUTEX_COUNT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_req_valid,
    output logic           o_req_ready,
    input  wire t_lock_req i_req,
    output logic           o_rsp_valid,
    input  wire logic      i_rsp_ready,
    output t_lock_rsp      o_rsp
);

    localparam int AW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;

    // Clearing pass after reset.
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Update stage: the request whose word is being read out of the RAM.
    logic          r_req_valid;
    t_lock_req     r_req;
    logic [AW-1:0] r_req_addr;

    // Forwarding of a word written in the same cycle the next request read it.
    logic          r_fwd_hit;
    t_mutex_word   r_fwd_word;

    // Response register.
    logic          r_rsp_valid;
    t_lock_rsp     r_rsp;

    logic          req_fire;
    logic          advance;
    logic [AW-1:0] in_addr;
    logic [WORD_W-1:0] ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    t_mutex_word   v;
    t_mutex_word   n_word;
    logic          word_we;
    logic          upd_we;
    t_lock_rsp     n_rsp;
    logic          in_range;
    logic          is_free;
    logic          owner_match;

    // The update stage moves on when the response register is empty or drained.
    assign advance     = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = !r_clearing && (!r_req_valid || advance);
    assign req_fire    = i_req_valid && o_req_ready;
    assign in_addr     = AW'(i_req.mutex_index);
    assign upd_we      = r_req_valid && advance && word_we;

    assign ram_we    = r_clearing || upd_we;
    assign ram_waddr = r_clearing ? r_clr_addr : r_req_addr;
    assign ram_wdata = r_clearing ? '0 : n_word;

    rmlt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MUTEX_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (req_fire),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(MUTEX_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else if (req_fire) begin
            r_req_valid <= 1'b1;
            r_fwd_hit   <= upd_we && (r_req_addr == in_addr);
        end else if (advance) begin
            r_req_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req      <= i_req;
            r_req_addr <= in_addr;
            r_fwd_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (advance) begin
            r_rsp_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_req_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Word update. The current word comes from the RAM unless the previous
    // request rewrote it in the very cycle this one was read.
    assign v           = r_fwd_hit ? r_fwd_word : t_mutex_word'(ram_rdata);
    assign in_range    = 32'(r_req.mutex_index) < MUTEX_COUNT;
    // Unlocked with no owner and no count: the word holds only kind and shared.
    assign is_free     = (v.owner == '0) && (v.count == '0) && (v.lock_st == LK_UNLOCKED);
    assign owner_match = (v.lock_st != LK_UNLOCKED) && (v.owner == r_req.thread_id);

    always_comb begin
        n_word        = v;
        word_we       = 1'b0;
        n_rsp.status  = STATUS_INVALID;
        n_rsp.wake_one = 1'b0;
        if (in_range) begin
            unique case (r_req.mode)
                MODE_INIT: begin
                    if (r_req.mutex_kind != KIND_REJECTED) begin
                        n_word       = '0;
                        n_word.kind  = r_req.mutex_kind;
                        word_we      = 1'b1;
                        n_rsp.status = STATUS_OK;
                    end
                end
                MODE_LOCK: begin
                    if (v.kind == KIND_NORMAL) begin
                        // A held normal lock, or any retry, leaves it marked
                        // as having waiters.
                        n_word         = '0;
                        n_word.shared  = v.shared;
                        n_word.lock_st = (!r_req.retry && is_free) ? LK_LOCKED : LK_WAITERS;
                        word_we        = 1'b1;
                        n_rsp.status   = is_free ? STATUS_OK : STATUS_MUST_WAIT;
                    end else if (v.kind == KIND_REJECTED || r_req.thread_id == '0) begin
                        n_rsp.status = STATUS_INVALID;
                    end else if (owner_match) begin
                        if (v.kind == KIND_ERRCHECK) begin
                            n_rsp.status = STATUS_DEADLOCK;
                        end else if (&v.count) begin
                            n_rsp.status = STATUS_COUNT_FULL;
                        end else begin
                            n_word.count = v.count + 1'b1;
                            word_we      = 1'b1;
                            n_rsp.status = STATUS_OK;
                        end
                    end else if (is_free) begin
                        n_word.owner   = r_req.thread_id;
                        n_word.lock_st = r_req.retry ? LK_WAITERS : LK_LOCKED;
                        word_we        = 1'b1;
                        n_rsp.status   = STATUS_OK;
                    end else begin
                        if (v.lock_st == LK_LOCKED) begin
                            n_word.lock_st = LK_WAITERS;
                            word_we        = 1'b1;
                        end
                        n_rsp.status = STATUS_MUST_WAIT;
                    end
                end
                MODE_TRYLOCK: begin
                    if (v.kind == KIND_REJECTED) begin
                        n_rsp.status = STATUS_INVALID;
                    end else if (v.kind != KIND_NORMAL && owner_match) begin
                        if (v.kind == KIND_ERRCHECK) begin
                            n_rsp.status = STATUS_DEADLOCK;
                        end else if (&v.count) begin
                            n_rsp.status = STATUS_COUNT_FULL;
                        end else begin
                            n_word.count = v.count + 1'b1;
                            word_we      = 1'b1;
                            n_rsp.status = STATUS_OK;
                        end
                    end else if (v.kind != KIND_NORMAL && r_req.thread_id == '0) begin
                        n_rsp.status = STATUS_INVALID;
                    end else if (!is_free) begin
                        n_rsp.status = STATUS_BUSY;
                    end else begin
                        // Normal mutexes record no owner.
                        n_word.owner   = (v.kind == KIND_NORMAL) ? '0 : r_req.thread_id;
                        n_word.lock_st = LK_LOCKED;
                        word_we        = 1'b1;
                        n_rsp.status   = STATUS_OK;
                    end
                end
                MODE_UNLOCK: begin
                    if (v.kind == KIND_NORMAL) begin
                        n_word         = '0;
                        n_word.shared  = v.shared;
                        word_we        = 1'b1;
                        n_rsp.status   = STATUS_OK;
                        // Only a plain locked word without waiters wakes nobody.
                        n_rsp.wake_one = !((v.owner == '0) && (v.count == '0)
                                           && (v.lock_st == LK_LOCKED));
                    end else if (v.kind == KIND_REJECTED) begin
                        n_rsp.status = STATUS_INVALID;
                    end else if (v.owner != r_req.thread_id) begin
                        n_rsp.status = STATUS_NOT_OWNER;
                    end else if (v.count != '0) begin
                        n_word.count = v.count - 1'b1;
                        word_we      = 1'b1;
                        n_rsp.status = STATUS_OK;
                    end else begin
                        n_word         = '0;
                        n_word.kind    = v.kind;
                        n_word.shared  = v.shared;
                        word_we        = 1'b1;
                        n_rsp.status   = STATUS_OK;
                        n_rsp.wake_one = (v.lock_st == LK_WAITERS);
                    end
                end
                default: begin
                    n_rsp.status = STATUS_INVALID;
                end
            endcase
        end
    end

    // No request enters while the table is being cleared.
    `RMLT_ASSERT_NEVER(a_no_req_while_clearing, i_clk, i_rst_n, r_clearing && (r_req_valid || o_req_ready), "request taken during clearing pass")
    // Forwarding is only ever armed for a request in the update stage.
    `RMLT_ASSERT_NEVER(a_fwd_has_req, i_clk, i_rst_n, r_fwd_hit && !r_req_valid, "forwarded word without a request")
    // A wake-one is only given with a successful unlock.
    `RMLT_ASSERT_NEVER(a_wake_only_ok, i_clk, i_rst_n, o_rsp_valid && o_rsp.wake_one && (o_rsp.status != STATUS_OK), "wake_one with a failing status")
    // A stalled update stage keeps its request.
    `RMLT_ASSERT_CLK(a_stall_holds_req, i_clk, i_rst_n, (r_req_valid && !advance) |=> (r_req_valid && $stable(r_req)), "update stage lost its request on a stall")

endmodule

`default_nettype wire

>>> tb/tb_recursive_mutex_lock_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: recursive mutex lock table unit
// Feeds init, lock, trylock and unlock request beats through the valid/ready
// request channel and checks every response beat against a local model of
// the mutex word table. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_recursive_mutex_lock_table_unit;
    import rmlt_pkg::*;

    // Cycles without any beat on either channel before the run is abandoned.
    // The limit leaves a wide margin over the clearing pass after reset and over
    // the longest stall patterns.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last response, to catch stray response beats.
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_BEATS   = 1650;
    // Largest value of the 11-bit recursion count.
    localparam int COUNT_MAX      = (1 << CNT_W) - 1;

    // Receiver stall styles. Each lasts for a random stretch of cycles.
    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_RHYTHM = 3;

    typedef struct {
        t_lock_req req;
        bit        hold_off;   // wait until every response is back first
    } t_pending_req;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_req_valid = 1'b0;
    t_lock_req i_req       = '0;
    logic      i_rsp_ready = 1'b0;
    logic      o_req_ready;
    logic      o_rsp_valid;
    t_lock_rsp o_rsp;

    recursive_mutex_lock_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Local copy of the mutex word table, updated as request beats are taken.
    t_mutex_word  mutex_words [MUTEX_COUNT_DEF];
    t_pending_req lock_req_backlog [$];
    t_lock_rsp    rsp_awaited [$];
    bit           hold_next = 1'b0;
    bit           req_beat_taken = 1'b0;
    int           error_cnt = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The owner locks a recursive or errorcheck word again. Errorcheck words
    // refuse with deadlock; recursive words count up until the count is full.
    function automatic t_status relock_by_owner(ref t_mutex_word w);
        if (w.kind == KIND_ERRCHECK) begin
            return STATUS_DEADLOCK;
        end
        if (w.count == CNT_W'(COUNT_MAX)) begin
            return STATUS_COUNT_FULL;
        end
        w.count = w.count + 1'b1;
        return STATUS_OK;
    endfunction

    // Applies one request to the local table and returns the response that
    // the block must give for it.
    function automatic t_lock_rsp mutex_table_step(input t_lock_req req);
        t_lock_rsp   rsp;
        t_mutex_word w;
        t_mutex_word idle_w;   // same kind and shared bit, nothing held
        t_mutex_word held_w;   // normal word held once, no waiters
        logic [TID_W-1:0] self;

        rsp.status   = STATUS_INVALID;
        rsp.wake_one = 1'b0;
        if (int'(req.mutex_index) >= MUTEX_COUNT_DEF) begin
            return rsp;
        end
        w              = mutex_words[req.mutex_index];
        self           = req.thread_id;
        idle_w         = '0;
        idle_w.kind    = w.kind;
        idle_w.shared  = w.shared;
        held_w         = idle_w;
        held_w.lock_st = LK_LOCKED;

        case (req.mode)
            MODE_INIT: begin
                if (req.mutex_kind != KIND_REJECTED) begin
                    w          = '0;
                    w.kind     = req.mutex_kind;
                    rsp.status = STATUS_OK;
                end
            end
            MODE_LOCK: begin
                if (w.kind == KIND_NORMAL) begin
                    // A normal word only tracks its lock state. A held word
                    // or a retry leaves it marked as having waiters.
                    if (!req.retry && w == idle_w) begin
                        w.lock_st  = LK_LOCKED;
                        rsp.status = STATUS_OK;
                    end else begin
                        rsp.status = (w == idle_w) ? STATUS_OK : STATUS_MUST_WAIT;
                        w          = idle_w;
                        w.lock_st  = LK_WAITERS;
                    end
                end else if (w.kind == KIND_REJECTED || self == '0) begin
                    rsp.status = STATUS_INVALID;
                end else if (w.lock_st != LK_UNLOCKED && w.owner == self) begin
                    rsp.status = relock_by_owner(w);
                end else if (w == idle_w) begin
                    w.owner    = self;
                    w.lock_st  = req.retry ? LK_WAITERS : LK_LOCKED;
                    rsp.status = STATUS_OK;
                end else begin
                    if (w.lock_st == LK_LOCKED) begin
                        w.lock_st = LK_WAITERS;
                    end
                    rsp.status = STATUS_MUST_WAIT;
                end
            end
            MODE_TRYLOCK: begin
                if (w.kind == KIND_REJECTED) begin
                    rsp.status = STATUS_INVALID;
                end else if (w.kind != KIND_NORMAL && w.lock_st != LK_UNLOCKED &&
                             w.owner == self) begin
                    rsp.status = relock_by_owner(w);
                end else if (w.kind != KIND_NORMAL && self == '0) begin
                    rsp.status = STATUS_INVALID;
                end else if (w != idle_w) begin
                    rsp.status = STATUS_BUSY;
                end else begin
                    // Normal words never record an owner.
                    w.owner    = (w.kind == KIND_NORMAL) ? '0 : self;
                    w.lock_st  = LK_LOCKED;
                    rsp.status = STATUS_OK;
                end
            end
            default: begin
                if (w.kind == KIND_NORMAL) begin
                    // Anything but a plain single hold needs a wake, even
                    // a word that was already unlocked.
                    rsp.wake_one = (w != held_w);
                    w            = idle_w;
                    rsp.status   = STATUS_OK;
                end else if (w.kind == KIND_REJECTED) begin
                    rsp.status = STATUS_INVALID;
                end else if (w.owner != self) begin
                    rsp.status = STATUS_NOT_OWNER;
                end else if (w.count != '0) begin
                    w.count    = w.count - 1'b1;
                    rsp.status = STATUS_OK;
                end else begin
                    rsp.wake_one = (w.lock_st == LK_WAITERS);
                    w            = idle_w;
                    rsp.status   = STATUS_OK;
                end
            end
        endcase
        mutex_words[req.mutex_index] = w;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    task automatic queue_req(input t_mode mode, input logic [INDEX_W-1:0] idx,
                             input logic [TID_W-1:0] tid, input logic [1:0] kind,
                             input logic retry);
        t_pending_req p;
        p.req.mode        = mode;
        p.req.mutex_index = idx;
        p.req.thread_id   = tid;
        p.req.mutex_kind  = kind;
        p.req.retry       = retry;
        p.hold_off        = hold_next;
        hold_next         = 1'b0;
        lock_req_backlog.push_back(p);
    endtask

    // A rival thread tries its luck: lock, trylock or unlock.
    task automatic queue_rival(input logic [INDEX_W-1:0] idx, input logic [TID_W-1:0] tid);
        queue_req(t_mode'($urandom_range(MODE_LOCK, MODE_UNLOCK)), idx, tid,
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    // Most traffic goes to a few words at both ends of the table so that
    // sessions collide; the rest is spread over the whole index range.
    function automatic logic [INDEX_W-1:0] pick_index();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            return INDEX_W'($urandom_range(0, MUTEX_COUNT_DEF - 1));
        end
        n = $urandom_range(0, 7);
        return INDEX_W'((n < 4) ? n : n + MUTEX_COUNT_DEF - 8);
    endfunction

    function automatic logic [TID_W-1:0] pick_tid();
        case ($urandom_range(0, 7))
            0:       return 16'h0001;
            1:       return 16'h0002;
            2:       return 16'hffff;
            3:       return 16'h8000;
            4:       return 16'h0000;
            default: return TID_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // One well-formed session: acquire, maybe relock a few times, maybe get
    // interrupted by a rival, then release as often as acquired.
    task automatic queue_session();
        logic [INDEX_W-1:0] idx;
        logic [TID_W-1:0]   owner_tid;
        logic [TID_W-1:0]   rival_tid;
        int                 depth;

        idx       = pick_index();
        owner_tid = pick_tid();
        rival_tid = pick_tid();
        depth     = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) begin
            queue_req(MODE_INIT, idx, pick_tid(), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
        end
        repeat (depth + 1) begin
            queue_req(($urandom_range(0, 2) != 0) ? MODE_LOCK : MODE_TRYLOCK, idx,
                      owner_tid, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 3) == 0));
        end
        if ($urandom_range(0, 1) != 0) begin
            queue_rival(idx, rival_tid);
        end
        repeat (depth + 1) begin
            queue_req(MODE_UNLOCK, idx, owner_tid, 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
        end
        // The rival comes back after its wait, as a woken thread would.
        if ($urandom_range(0, 2) == 0) begin
            queue_req(MODE_LOCK, idx, rival_tid, 2'($urandom_range(0, 3)), 1'b1);
            queue_req(MODE_UNLOCK, idx, rival_tid, 2'($urandom_range(0, 3)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Run control: reset, stimulus, end of test
    // ------------------------------------------------------------------------
    initial begin
        int random_goal;
        bit mid_hold_done;

        foreach (mutex_words[i]) mutex_words[i] = '0;
        mid_hold_done = 1'b0;

        // Directed part. A normal word: plain lock, held lock, busy trylock,
        // unlock by anyone, unlock of an unlocked word, lock on retry.
        queue_req(MODE_INIT,    6'd0,  16'd0,     KIND_NORMAL,    1'b0);
        queue_req(MODE_LOCK,    6'd0,  16'd5,     KIND_NORMAL,    1'b0);
        queue_req(MODE_LOCK,    6'd0,  16'd6,     KIND_NORMAL,    1'b0);
        queue_req(MODE_TRYLOCK, 6'd0,  16'd6,     KIND_NORMAL,    1'b0);
        queue_req(MODE_UNLOCK,  6'd0,  16'd9,     KIND_NORMAL,    1'b0);
        queue_req(MODE_UNLOCK,  6'd0,  16'd9,     KIND_NORMAL,    1'b0);
        queue_req(MODE_LOCK,    6'd0,  16'd5,     KIND_NORMAL,    1'b1);
        queue_req(MODE_UNLOCK,  6'd0,  16'd5,     KIND_NORMAL,    1'b0);
        // Rejected kind on init.
        queue_req(MODE_INIT,    6'd1,  16'd0,     KIND_REJECTED,  1'b0);
        // A recursive word at the top index: zero thread id on both lock
        // paths, recursion, a rival, unlock by a non-owner, full release.
        queue_req(MODE_INIT,    6'd63, 16'd0,     KIND_RECURSIVE, 1'b0);
        queue_req(MODE_LOCK,    6'd63, 16'd0,     KIND_NORMAL,    1'b0);
        queue_req(MODE_TRYLOCK, 6'd63, 16'd0,     KIND_NORMAL,    1'b0);
        queue_req(MODE_LOCK,    6'd63, 16'hffff,  KIND_NORMAL,    1'b0);
        queue_req(MODE_TRYLOCK, 6'd63, 16'hffff,  KIND_NORMAL,    1'b0);
        queue_req(MODE_LOCK,    6'd63, 16'd1,     KIND_NORMAL,    1'b0);
        queue_req(MODE_UNLOCK,  6'd63, 16'd1,     KIND_NORMAL,    1'b0);
        queue_req(MODE_UNLOCK,  6'd63, 16'hffff,  KIND_NORMAL,    1'b0);
        queue_req(MODE_UNLOCK,  6'd63, 16'hffff,  KIND_NORMAL,    1'b0);
        // Unlock of an unowned word by thread zero matches the empty owner.
        queue_req(MODE_UNLOCK,  6'd63, 16'd0,     KIND_NORMAL,    1'b0);
        // An errorcheck word: relock by the owner is a deadlock.
        queue_req(MODE_INIT,    6'd62, 16'd0,     KIND_ERRCHECK,  1'b0);
        queue_req(MODE_TRYLOCK, 6'd62, 16'd7,     KIND_NORMAL,    1'b0);
        queue_req(MODE_LOCK,    6'd62, 16'd7,     KIND_NORMAL,    1'b0);
        queue_req(MODE_TRYLOCK, 6'd62, 16'd7,     KIND_NORMAL,    1'b0);
        queue_req(MODE_LOCK,    6'd62, 16'd8,     KIND_NORMAL,    1'b1);
        queue_req(MODE_UNLOCK,  6'd62, 16'd7,     KIND_NORMAL,    1'b0);

        // Random part: mostly sessions, some single beats of pure noise.
        // The first random beat and one in the middle wait for a full drain.
        random_goal = lock_req_backlog.size() + RANDOM_BEATS;
        hold_next   = 1'b1;
        while (lock_req_backlog.size() < random_goal) begin
            if (!mid_hold_done && lock_req_backlog.size() >= random_goal - RANDOM_BEATS / 2) begin
                hold_next     = 1'b1;
                mid_hold_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                queue_session();
            end else begin
                queue_req(t_mode'($urandom_range(0, 3)),
                          INDEX_W'($urandom_range(0, MUTEX_COUNT_DEF - 1)),
                          TID_W'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The backlog and the request valid only change on falling edges, and
        // the awaited responses only on rising edges; poll each on the other.
        while (lock_req_backlog.size() != 0 || i_req_valid) @(posedge i_clk);
        @(negedge i_clk);
        while (rsp_awaited.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("PASS recursive_mutex_lock_table_unit");
        end else begin
            $display("FAIL recursive_mutex_lock_table_unit");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver. Works in bursts of beats with random gaps between them.
    // A beat that is marked hold-off is not offered until every response
    // beat already due has been taken. Valid and payload are computed first
    // and assigned once per edge, so a valid that stays high never dips.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        logic         nxt_valid;
        t_lock_req    nxt_req;
        t_pending_req p;

        nxt_valid = i_req_valid;
        nxt_req   = i_req;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_req_valid || req_beat_taken) begin
            nxt_valid = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (lock_req_backlog.size() != 0 &&
                         (!lock_req_backlog[0].hold_off || rsp_awaited.size() == 0)) begin
                p         = lock_req_backlog.pop_front();
                nxt_valid = 1'b1;
                nxt_req   = p.req;
                if (burst_left <= 1) begin
                    // A new burst; about a quarter of bursts start with no gap,
                    // which gives long stretches of back-to-back beats.
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
        i_req_valid <= nxt_valid;
        i_req       <= nxt_req;
    end

    // ------------------------------------------------------------------------
    // Response receiver. Switches between stall styles at random stretches:
    // always ready, coin toss, mostly stalled, and a fixed rhythm.
    // ------------------------------------------------------------------------
    int rx_style     = RX_ALWAYS;
    int rx_style_left = 0;
    int rx_tick      = 0;

    always @(negedge i_clk) begin
        logic nxt_ready;

        if (rx_style_left == 0) begin
            rx_style      = $urandom_range(RX_ALWAYS, RX_RHYTHM);
            rx_style_left = $urandom_range(16, 96);
        end else begin
            rx_style_left--;
        end
        rx_tick++;
        case (rx_style)
            RX_ALWAYS: nxt_ready = 1'b1;
            RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: nxt_ready = ($urandom_range(0, 3) == 0);
            default:   nxt_ready = ((rx_tick % 7) >= 3);
        endcase
        i_rsp_ready <= nxt_ready;
    end

    // ------------------------------------------------------------------------
    // Monitor. At each rising edge the response beat, if any, is checked
    // against the oldest prediction, and a request beat, if any, is run
    // through the local table to predict its response.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lock_rsp want;

        req_beat_taken <= i_rst_n && i_req_valid && o_req_ready;
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (rsp_awaited.size() == 0) begin
                    $display("%0t: response beat with none expected, got status %0d wake %0b",
                             $time, o_rsp.status, o_rsp.wake_one);
                    error_cnt++;
                end else begin
                    want = rsp_awaited.pop_front();
                    if (o_rsp.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d got %0d",
                                 $time, want.status, o_rsp.status);
                        error_cnt++;
                    end
                    if (o_rsp.wake_one !== want.wake_one) begin
                        $display("%0t: wake_one mismatch, expected %0b got %0b",
                                 $time, want.wake_one, o_rsp.wake_one);
                        error_cnt++;
                    end
                end
            end
            if (i_req_valid && o_req_ready) begin
                rsp_awaited.push_back(mutex_table_step(i_req));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no beat moves on either channel for too
    // long. The count restarts on every beat and is held during reset.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("FAIL recursive_mutex_lock_table_unit");
                $finish;
            end
        end
    end

endmodule
